// ===== hw/rtl/bfsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfsa_pkg
// Shared types and constants of the best-fit shelf allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfsa_pkg;

  localparam int unsigned BIN_COUNT_DEF = 64;

  localparam int unsigned VOL_W  = 16;
  localparam int unsigned CAP_W  = 12;
  localparam int unsigned CNT_W  = 10;
  localparam int unsigned BIN_W  = 7;
  localparam int unsigned STAT_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 12'd2048;
  localparam logic [CNT_W-1:0] CNT_MAX   = 10'd1023;

  typedef enum logic [STAT_W-1:0] {
    ST_PLACED    = 2'd0,
    ST_ALREADY   = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_NO_FIT    = 2'd3
  } status_e;

  typedef struct packed {
    logic load;
    logic rd;
    logic wr;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    logic early;
    logic scan_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bfsa_req_if.sv =====
// ----------------------------------------------------------------------------
// bfsa_req_if
// Request channel: valid/ready with one allocation request.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfsa_req_if
  import bfsa_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [VOL_W-1:0] volume;
  logic             already_placed;
  logic             awaiting_pickup;

  modport source (
    output valid, volume, already_placed, awaiting_pickup,
    input  ready
  );

  modport sink (
    input  valid, volume, already_placed, awaiting_pickup,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/bfsa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bfsa_rsp_if
// Response channel: valid/ready with one allocation result.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfsa_rsp_if
  import bfsa_pkg::*;
;
  logic             valid;
  logic             ready;
  status_e          status;
  logic [BIN_W-1:0] bin_number;
  logic [CNT_W-1:0] slot_number;
  logic             zone_b;

  modport source (
    output valid, status, bin_number, slot_number, zone_b,
    input  ready
  );

  modport sink (
    input  valid, status, bin_number, slot_number, zone_b,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/bfsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfsa_ctrl
// Sequencer: request check, bin scan, write-back and result transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsa_ctrl
  import bfsa_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    req_valid_i,
  output logic         req_ready_o,
  output logic         rsp_valid_o,
  input  wire logic    rsp_ready_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_SCAN  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   out_free;

  assign out_free    = !out_vld_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_vld_q;

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = sts_i.early ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        cmd_o.rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.wr = 1'b1;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.fin) begin
      out_vld_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bfsa_dp.sv =====
// ----------------------------------------------------------------------------
// bfsa_dp
// Datapath: capacity register, bin table, best-fit compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsa_dp
  import bfsa_pkg::*;
#(
  parameter int unsigned BIN_COUNT = BIN_COUNT_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i,
  input  wire logic [VOL_W-1:0] volume_i,
  input  wire logic             already_placed_i,
  input  wire logic             awaiting_pickup_i,
  input  wire dp_cmd_t          cmd_i,
  output dp_sts_t               sts_o,
  output status_e               status_o,
  output logic [BIN_W-1:0]      bin_number_o,
  output logic [CNT_W-1:0]      slot_number_o,
  output logic                  zone_b_o
);

  localparam int unsigned IDX_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int unsigned ENT_W = CAP_W + CNT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BIN_COUNT - 1);

  logic [CAP_W-1:0] cap_q;
  logic [VOL_W-1:0] vol_q;
  logic             placed_q;
  logic             await_q;

  logic [ENT_W-1:0] bin_mem [BIN_COUNT];
  logic [BIN_COUNT-1:0] ent_vld_q;

  logic [IDX_W-1:0] rd_addr_q;
  logic [ENT_W-1:0] rd_data_q;
  logic             rd_vld_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             cmp_en_q;

  logic             found_q;
  logic [IDX_W-1:0] best_idx_q;
  logic [CAP_W-1:0] best_space_q;
  logic [CNT_W-1:0] best_cnt_q;

  logic [CAP_W-1:0] ent_space;
  logic [CNT_W-1:0] ent_cnt;
  logic             better;
  logic             too_large;
  logic [CNT_W-1:0] cnt_next;
  logic [CAP_W-1:0] space_next;
  logic [BIN_W-1:0] bin_full;
  status_e          status_d;
  logic             placed_ok;

  assign too_large  = vol_q > {{(VOL_W-CAP_W){1'b0}}, cap_q};
  assign ent_space  = rd_vld_q ? rd_data_q[ENT_W-1:CNT_W] : CAP_RESET;
  assign ent_cnt    = rd_vld_q ? rd_data_q[CNT_W-1:0] : '0;
  assign better     = (ent_space >= vol_q[CAP_W-1:0])
                      && (!found_q || (ent_space < best_space_q));
  assign cnt_next   = (best_cnt_q == CNT_MAX) ? CNT_MAX : best_cnt_q + CNT_W'(1);
  assign space_next = best_space_q - vol_q[CAP_W-1:0];
  assign bin_full   = BIN_W'(best_idx_q) + BIN_W'(1);

  assign sts_o.early     = placed_q || too_large;
  assign sts_o.scan_last = (rd_addr_q == LAST_IDX);

  always_comb begin
    if (placed_q) begin
      status_d = ST_ALREADY;
    end else if (too_large) begin
      status_d = ST_TOO_LARGE;
    end else if (!found_q) begin
      status_d = ST_NO_FIT;
    end else begin
      status_d = ST_PLACED;
    end
  end

  assign placed_ok = (status_d == ST_PLACED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= CAP_RESET;
      ent_vld_q <= '0;
      rd_addr_q <= '0;
      cmp_en_q  <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        rd_addr_q <= '0;
        found_q   <= 1'b0;
      end else begin
        if (cmd_i.rd) begin
          rd_addr_q <= rd_addr_q + IDX_W'(1);
        end
        if (cmp_en_q && better) begin
          found_q <= 1'b1;
        end
      end
      cmp_en_q <= cmd_i.rd;
      if (cmd_i.wr && found_q) begin
        ent_vld_q[best_idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      vol_q    <= volume_i;
      placed_q <= already_placed_i;
      await_q  <= awaiting_pickup_i;
    end
    if (cmd_i.rd) begin
      rd_data_q <= bin_mem[rd_addr_q];
      rd_vld_q  <= ent_vld_q[rd_addr_q];
      cmp_idx_q <= rd_addr_q;
    end
    if (cmp_en_q && better) begin
      best_idx_q   <= cmp_idx_q;
      best_space_q <= ent_space;
      best_cnt_q   <= ent_cnt;
    end
    if (cmd_i.wr && found_q) begin
      bin_mem[best_idx_q] <= {space_next, cnt_next};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      status_o      <= status_d;
      bin_number_o  <= placed_ok ? bin_full : '0;
      slot_number_o <= placed_ok ? cnt_next : '0;
      zone_b_o      <= placed_ok && !await_q;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/best_fit_shelf_allocator.sv =====
// Sequence: an ignored or rejected request goes from S_CHECK straight to
//   S_DONE; a scanned one passes S_SCAN over every bin, S_DRAIN and S_WRITE.
// Throughput: one request at a time, taken only in S_IDLE;
//   the scan reads one bin a cycle from the single-port bin table.
// Reset: capacity returns to 2048; per-bin valid flags make every bin read
//   as 2048 free space with a zero count, with no clearing pass.
// ----------------------------------------------------------------------------
// best_fit_shelf_allocator
// Best-fit bin allocator with per-bin remaining space and item count.
// ----------------------------------------------------------------------------
`default_nettype none

module best_fit_shelf_allocator
  import bfsa_pkg::*;
#(
  parameter int unsigned BIN_COUNT = BIN_COUNT_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i,
  bfsa_req_if.sink              req_i,
  bfsa_rsp_if.source            rsp_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  bfsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bfsa_dp #(
    .BIN_COUNT (BIN_COUNT)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .volume_i          (req_i.volume),
    .already_placed_i  (req_i.already_placed),
    .awaiting_pickup_i (req_i.awaiting_pickup),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .status_o          (rsp_o.status),
    .bin_number_o      (rsp_o.bin_number),
    .slot_number_o     (rsp_o.slot_number),
    .zone_b_o          (rsp_o.zone_b)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/bfsa_chk.sv =====
// ----------------------------------------------------------------------------
// bfsa_chk
// Port-level checks of the best-fit shelf allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsa_chk
  import bfsa_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             req_valid_i,
  input wire logic             req_ready_i,
  input wire logic             rsp_valid_i,
  input wire logic             rsp_ready_i,
  input wire status_e          status_i,
  input wire logic [BIN_W-1:0] bin_number_i,
  input wire logic [CNT_W-1:0] slot_number_i,
  input wire logic             zone_b_i
);

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in work");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i)
      && $stable(bin_number_i) && $stable(slot_number_i) && $stable(zone_b_i))
    else $error("stalled result changed");

  a_unplaced_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i != ST_PLACED) |->
      (bin_number_i == '0) && (slot_number_i == '0) && !zone_b_i)
    else $error("unplaced result carries placement fields");

  a_placed_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_PLACED) |-> (slot_number_i != '0))
    else $error("placed result with zero slot");

endmodule

bind best_fit_shelf_allocator bfsa_chk u_bfsa_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .status_i      (rsp_o.status),
  .bin_number_i  (rsp_o.bin_number),
  .slot_number_i (rsp_o.slot_number),
  .zone_b_i      (rsp_o.zone_b)
);

`default_nettype wire
